@@ rtl/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helper functions of the 32-lane page checksum.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned LANES       = 32;
  localparam int unsigned LANE_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] MIX_PRIME = 32'd16777619;
  localparam int unsigned MIX_SHIFT = 17;

  localparam logic [16:0] MOD_ONE = 17'd65535;
  localparam logic [16:0] MOD_TWO = 17'd131070;

  localparam logic [31:0] LANE_BASE [LANES] = '{
    32'h5B1F36E9, 32'hB8525960, 32'h02AB50AA, 32'h1DE66D2A,
    32'h79FF467A, 32'h9BB9F8A3, 32'h217E7CD2, 32'h83E13D2C,
    32'hF8D4474F, 32'hE39EB970, 32'h42C6AE16, 32'h993216FA,
    32'h7B093B5D, 32'h98DAFF3C, 32'hF718902A, 32'h0B1C9CDB,
    32'hE58F764B, 32'h187636BC, 32'h5D7B3BB1, 32'hE73DE7DE,
    32'h92BEC979, 32'hCCA6C0B2, 32'h304A0979, 32'h85AA43D4,
    32'h783125BB, 32'h6CA8EAA2, 32'hE407EAC6, 32'h4B5CFC3E,
    32'h9FBF8C76, 32'h15CA20BE, 32'hF2CA9FD3, 32'h959BD756
  };

  // one word queued between front and back
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } beat_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic [LANE_W-1:0] lane_idx;
    logic              running;
  } bk_status_t;

  function automatic logic [31:0] mix_step(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] t;
    logic [31:0] p;
    t = acc ^ w;
    p = t * MIX_PRIME;
    return p ^ (t >> MIX_SHIFT);
  endfunction

  // (fold mod 65535) + 1, using 2^16 == 1 mod 65535
  function automatic logic [15:0] mod_plus_one(input logic [31:0] fold);
    logic [16:0] s;
    logic [16:0] r;
    s = {1'b0, fold[31:16]} + {1'b0, fold[15:0]};
    if (s >= MOD_TWO) begin
      r = s - MOD_TWO;
    end else if (s >= MOD_ONE) begin
      r = s - MOD_ONE;
    end else begin
      r = s;
    end
    return r[15:0] + 16'd1;
  endfunction

endpackage

@@ rtl/pfc_front.sv @@
// ----------------------------------------------------------------------------
// pfc_front
// Input side: takes page words and queues them for the lane engine.
// ----------------------------------------------------------------------------
module pfc_front #(
  parameter int unsigned DEPTH = pfc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_word,
  input  logic           in_last,
  output logic           q_valid,
  output pfc_pkg::beat_t q_beat,
  input  logic           q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pfc_pkg::beat_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push;
  logic            pop;

  assign in_ready = (cnt_r != CW'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_beat   = mem_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_pop & q_valid;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{word: in_word, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/pfc_back.sv @@
// ----------------------------------------------------------------------------
// pfc_back
// Lane engine: mixes words into the lanes, walks the lanes at page end and
// holds the result beat.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pfc_pkg::beat_t      q_beat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_page_sum,
  output logic [31:0]         out_folded_sum,
  output logic                out_short_page,
  output pfc_pkg::bk_status_t status
);

  localparam int unsigned LW = pfc_pkg::LANE_W;

  typedef enum logic [2:0] {
    S_RUN = 3'b001,
    S_FIN = 3'b010,
    S_OUT = 3'b100
  } state_t;

  state_t          state_r;
  logic [31:0]     lanes_r [pfc_pkg::LANES];
  logic [LW-1:0]   idx_r;
  logic            seeded_r;
  logic            short_r;
  logic [LW:0]     cnt_r;
  logic [31:0]     v1_r;
  logic            v1_vld_r;
  logic [31:0]     fold_r;
  logic            out_valid_r;
  logic [15:0]     page_sum_r;
  logic [31:0]     folded_r;
  logic            short_out_r;
  logic            take;
  logic            emit;

  assign q_pop          = (state_r == S_RUN) && q_valid;
  assign take           = q_pop;
  assign emit           = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;
  assign out_page_sum   = page_sum_r;
  assign out_folded_sum = folded_r;
  assign out_short_page = short_out_r;
  assign status         = '{lane_idx: idx_r, running: (state_r == S_RUN)};

  // lane store: one update per word, all lanes back to base at page end
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      for (int i = 0; i < pfc_pkg::LANES; i++) begin
        lanes_r[i] <= pfc_pkg::LANE_BASE[i];
      end
    end else if (take) begin
      lanes_r[idx_r] <= pfc_pkg::mix_step(lanes_r[idx_r], q_beat.word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      idx_r       <= '0;
      seeded_r    <= 1'b0;
      cnt_r       <= '0;
      v1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_RUN: begin
          if (take) begin
            idx_r <= idx_r + LW'(1);
            if (idx_r == LW'(pfc_pkg::LANES - 1)) begin
              seeded_r <= 1'b1;
            end
            if (q_beat.last) begin
              state_r  <= S_FIN;
              cnt_r    <= '0;
              v1_vld_r <= 1'b0;
            end
          end
        end
        S_FIN: begin
          // two-stage walk: first zero round, then second round into the fold
          v1_vld_r <= (cnt_r < (LW+1)'(pfc_pkg::LANES));
          cnt_r    <= cnt_r + (LW+1)'(1);
          if (cnt_r == (LW+1)'(pfc_pkg::LANES)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (emit) begin
            idx_r    <= '0;
            seeded_r <= 1'b0;
            state_r  <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take && q_beat.last) begin
      short_r <= !(seeded_r || (idx_r == LW'(pfc_pkg::LANES - 1)));
      fold_r  <= '0;
    end
    if (state_r == S_FIN) begin
      v1_r <= pfc_pkg::mix_step(lanes_r[cnt_r[LW-1:0]], 32'd0);
      if (v1_vld_r) begin
        fold_r <= fold_r ^ pfc_pkg::mix_step(v1_r, 32'd0);
      end
    end
    if (emit) begin
      page_sum_r  <= pfc_pkg::mod_plus_one(fold_r);
      folded_r    <= fold_r;
      short_out_r <= short_r;
    end
  end

endmodule

@@ rtl/parallel_fnv_page_checksum.sv @@
// ----------------------------------------------------------------------------
// parallel_fnv_page_checksum
// 32-lane FNV-style page checksum over a stream of 32-bit page words.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle within a page; after the last word the engine takes
//   no words while it walks the lanes and loads the result, nor while a finished
//   result waits on out_ready. From the last beat to out_valid with an empty queue,
//   the beat passes the input queue, then the 32 lanes are walked through the two
//   zero-round mixers one lane a cycle, then the result register is loaded.
// The input queue takes up to QUEUE_DEPTH beats while the lane engine finishes.
// Reset: lanes return to their base offsets, queue empties, no result pending.
module parallel_fnv_page_checksum #(
  parameter int unsigned QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_page_sum,
  output logic [31:0] out_folded_sum,
  output logic        out_short_page
);

  logic                q_valid;
  logic                q_pop;
  pfc_pkg::beat_t      q_beat;
  pfc_pkg::bk_status_t bk_status;

  pfc_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_beat   (q_beat),
    .q_pop    (q_pop)
  );

  pfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_beat         (q_beat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_page_sum   (out_page_sum),
    .out_folded_sum (out_folded_sum),
    .out_short_page (out_short_page),
    .status         (bk_status)
  );

  a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_page_sum != 16'd0))
    else $error("page sum of zero");

  a_sum_matches_fold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_page_sum == pfc_pkg::mod_plus_one(out_folded_sum)))
    else $error("page sum does not match folded sum");

  a_restart_after_page: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (bk_status.running && (bk_status.lane_idx == '0)))
    else $error("lane engine not restarted after result");

endmodule

@@ verif/tb_parallel_fnv_page_checksum.sv @@
// ----------------------------------------------------------------------------
// tb_parallel_fnv_page_checksum
// Streams pages of 32-bit words into the 32-lane page checksum with random
// gaps on the input side and random stalls on the result side. A lane-level
// predictor computes each page sum, and every result beat is compared with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_parallel_fnv_page_checksum;

  typedef struct packed {
    bit [15:0] page_sum;
    bit [31:0] folded_sum;
    bit        short_page;
  } page_result_t;

  class checksum_tracker;
    bit [31:0]    lane_seed [32];
    bit [31:0]    lanes [32];
    bit [4:0]     lane_pos;
    bit           seeded;
    page_result_t expected_sums [$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  pages_seen;
    int unsigned  short_pages;
    int unsigned  words_seen;

    function new();
      lane_seed = '{
        32'h5B1F36E9, 32'hB8525960, 32'h02AB50AA, 32'h1DE66D2A,
        32'h79FF467A, 32'h9BB9F8A3, 32'h217E7CD2, 32'h83E13D2C,
        32'hF8D4474F, 32'hE39EB970, 32'h42C6AE16, 32'h993216FA,
        32'h7B093B5D, 32'h98DAFF3C, 32'hF718902A, 32'h0B1C9CDB,
        32'hE58F764B, 32'h187636BC, 32'h5D7B3BB1, 32'hE73DE7DE,
        32'h92BEC979, 32'hCCA6C0B2, 32'h304A0979, 32'h85AA43D4,
        32'h783125BB, 32'h6CA8EAA2, 32'hE407EAC6, 32'h4B5CFC3E,
        32'h9FBF8C76, 32'h15CA20BE, 32'hF2CA9FD3, 32'h959BD756
      };
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 32; i++) lanes[i] = lane_seed[i];
      lane_pos = '0;
      seeded   = 1'b0;
    endfunction

    function bit [31:0] lane_mix(bit [31:0] acc, bit [31:0] w);
      bit [31:0] t;
      bit [31:0] prod;
      t    = acc ^ w;
      prod = t * 32'd16777619;
      return prod ^ (t >> 17);
    endfunction

    // fold in one accepted input beat; the last beat of a page queues a result
    function void note_word(bit [31:0] word, bit last);
      bit [31:0]    fold;
      page_result_t r;
      words_seen++;
      lanes[lane_pos] = lane_mix(lanes[lane_pos], word);
      if (lane_pos == 5'd31) seeded = 1'b1;
      lane_pos = lane_pos + 5'd1;
      if (!last) return;
      fold = '0;
      for (int i = 0; i < 32; i++) fold ^= lane_mix(lane_mix(lanes[i], 32'd0), 32'd0);
      r.folded_sum = fold;
      r.page_sum   = 16'((fold % 32'd65535) + 32'd1);
      r.short_page = !seeded;
      expected_sums.push_back(r);
      pages_seen++;
      if (!seeded) short_pages++;
      restart();
    endfunction

    function void check_result(bit [15:0] page_sum, bit [31:0] folded_sum, bit short_page);
      page_result_t want;
      results_checked++;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat page_sum=%h folded_sum=%h short_page=%b",
                   $realtime, page_sum, folded_sum, short_page);
        return;
      end
      want = expected_sums.pop_front();
      if (want.page_sum != page_sum || want.folded_sum != folded_sum ||
          want.short_page != short_page) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: page %0d exp/got page_sum %h/%h folded %h/%h short %b/%b",
                   $realtime, results_checked, want.page_sum, page_sum,
                   want.folded_sum, folded_sum, want.short_page, short_page);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_word;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_page_sum;
  logic [31:0] out_folded_sum;
  logic        out_short_page;

  checksum_tracker sb;
  bit              calm = 1'b0;

  parallel_fnv_page_checksum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_page_sum  (out_page_sum),
    .out_folded_sum(out_folded_sum),
    .out_short_page(out_short_page)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_page_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(1, 31);
      4, 5, 6:    return 32;
      7, 8:       return $urandom_range(33, 96);
      default:    return $urandom_range(97, 160);
    endcase
  endfunction

  // one input beat, optionally preceded by an idle burst
  task automatic drive_beat(bit [31:0] word, bit last, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_word(word, last);
  endtask

  task automatic send_page(int len, bit allow_gap);
    for (int i = 0; i < len; i++) drive_beat(pick_word(), i == len - 1, allow_gap);
  endtask

  // result side: random stall bursts until the calm tail
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_page_sum, out_folded_sum, out_short_page);
  end

  initial begin : main_seq
    int drain;
    int unsigned leftover;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    in_last  <= 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-beat pages at both word extremes, a two-beat page, a short page
    drive_beat(32'h0000_0000, 1'b1, 1'b0);
    drive_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
    drive_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
    drive_beat(32'h0000_0000, 1'b1, 1'b0);
    for (int i = 0; i < 20; i++)
      drive_beat(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i == 19, 1'b1);

    while (sb.words_seen < 1800) begin
      if (sb.words_seen >= 1450) calm = 1'b1;
      send_page(pick_page_len(), !calm && $urandom_range(0, 3) != 0);
    end
    in_valid <= 1'b0;
    in_last  <= 1'b0;

    drain = 0;
    while (sb.expected_sums.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    // catch any stray result beat after finalization
    repeat (80) @(posedge clk);

    leftover = sb.expected_sums.size();
    if (leftover != 0) begin
      sb.mismatches += leftover;
      $display("%0d expected page results never arrived", leftover);
    end
    $display("streamed %0d words in %0d pages (%0d short), %0d result beats checked",
             sb.words_seen, sb.pages_seen, sb.short_pages, sb.results_checked);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pfc_pkg.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/parallel_fnv_page_checksum.sv
verif/tb_parallel_fnv_page_checksum.sv
